/* hdl/mau_pkg.sv */
// Package for the modular arithmetic unit: operation codes, state and command types.
`timescale 1ns / 1ps
package mau_pkg;

    // Operation codes carried in the request word.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;
    localparam logic [2:0] OP_POW = 3'd5;

    localparam int EXP_BITS = 31;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISPATCH,
        S_POW_STEP,
        S_MUL_RUN,
        S_DONE
    } t_state;

    // Source selection for the shared multiplier.
    typedef enum logic [1:0] {
        MS_R_X,
        MS_X_X,
        MS_A_B,
        MS_A_R
    } t_mul_src;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     load;
        logic     red_a;
        logic     red_b;
        logic     pow_init;
        logic     pow_shift;
        logic     mul_start;
        t_mul_src mul_src;
        logic     mul_to_r;
        logic     mul_to_x;
        logic     mul_to_b;
        logic     set_simple;
        logic     set_zero_div;
        logic     emit;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic [2:0] op;
        logic       a_zero;
        logic       b_zero;
        logic       e_zero;
        logic       e_lsb;
        logic       mul_done;
    } t_status;

endpackage

/* hdl/mau_mulmod.sv */
// Bit-serial double-and-add modular multiplier, one operand bit per cycle.
`timescale 1ns / 1ps
module mau_mulmod #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_p
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc, r_x, r_y;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    dbl, dbl_r, add, add_r;
    logic [W-1:0]  n_acc;

    // One step: double, reduce, conditionally add, reduce.
    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        add   = dbl_r + {1'b0, r_x};
        add_r = (add >= {1'b0, i_m}) ? add - {1'b0, i_m} : add;
        n_acc = r_y[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy;
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done while busy");

    property p_acc_below_mod;
        @(posedge i_clk) disable iff (!i_rst_n) (r_busy && $past(i_start)) |-> r_acc == '0;
    endproperty
    a_acc_clear: assert property (p_acc_below_mod) else $error("accumulator not cleared");

    property p_start_idle;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy;
    endproperty
    a_start_busy: assert property (p_start_idle) else $error("start did not begin run");
endmodule

/* hdl/mau_datapath.sv */
// Datapath: operand registers, reduction, add/sub, and the shared multiplier.
`timescale 1ns / 1ps
module mau_datapath #(
    parameter int W = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [W-1:0]            i_cfg_data,
    input  logic [2:0]              i_req_type,
    input  logic [W-1:0]            i_operand_a,
    input  logic [W-1:0]            i_operand_b,
    input  logic [mau_pkg::EXP_BITS-1:0] i_exponent,
    input  mau_pkg::t_cmd           i_cmd,
    output mau_pkg::t_status        o_status,
    output logic                    o_result_strobe,
    output logic [W-1:0]            o_result_value,
    output logic                    o_zero_divide
);
    localparam int EB = mau_pkg::EXP_BITS;
    // The exponent register also holds modulus-2 for inverse and divide.
    localparam int XB = (W > EB) ? W : EB;
    localparam logic [W-1:0] MOD_RESET = W'(64'h7FFF_FFFF);

    logic [W-1:0]  r_mod, r_a, r_b, r_x, r_r, r_res;
    logic [2:0]    r_op;
    logic [XB-1:0] r_e;
    logic          r_zd, r_strobe;
    logic [W-1:0]  m, red_in, red_out, mul_x, mul_y, mul_p, simple;
    logic [W:0]    sum;
    logic          mul_done;

    // Effective modulus: values below two act as two.
    assign m = (r_mod < W'(2)) ? W'(2) : r_mod;

    // Modulus register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    // Reduction of an operand runs 1 * operand through the multiplier; the operand
    // goes on the bit-scanned side, which may hold any W-bit value.
    assign red_in = i_cmd.red_a ? r_a : r_b;
    assign red_out = red_in;

    // Add and subtract on reduced operands; other codes give zero.
    always_comb begin
        simple = '0;
        sum    = '0;
        if (r_op == mau_pkg::OP_ADD) begin
            sum = {1'b0, r_a} + {1'b0, r_b};
        end else begin
            sum = {1'b0, r_a} + {1'b0, m - r_b};
        end
        simple = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
        if (r_op != mau_pkg::OP_ADD && r_op != mau_pkg::OP_SUB) begin
            simple = '0;
        end
    end

    // Multiplier operand selection; reduction passes multiply by one.
    always_comb begin
        mul_x = r_a;
        mul_y = r_b;
        if (i_cmd.red_a || i_cmd.red_b) begin
            mul_x = W'(1);
            mul_y = red_out;
        end else begin
            unique case (i_cmd.mul_src)
                mau_pkg::MS_R_X: begin mul_x = r_r; mul_y = r_x; end
                mau_pkg::MS_X_X: begin mul_x = r_x; mul_y = r_x; end
                mau_pkg::MS_A_R: begin mul_x = r_a; mul_y = r_r; end
                default:         begin mul_x = r_a; mul_y = r_b; end
            endcase
        end
    end

    mau_mulmod #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .i_m     (m),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // Operand and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_req_type;
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
            r_e  <= XB'(i_exponent);
        end
        if (i_cmd.red_a && mul_done) begin
            r_a <= mul_p;
        end
        if (i_cmd.red_b && mul_done) begin
            r_b <= mul_p;
        end
        if (i_cmd.pow_init) begin
            r_r <= W'(1);
            unique case (r_op)
                mau_pkg::OP_DIV: begin
                    r_x <= r_b;
                    r_e <= XB'(m - W'(2));
                end
                mau_pkg::OP_INV: begin
                    r_x <= r_a;
                    r_e <= XB'(m - W'(2));
                end
                default: r_x <= r_a;
            endcase
        end
        if (i_cmd.pow_shift) begin
            r_e <= r_e >> 1;
        end
        if (mul_done && i_cmd.mul_to_r) r_r <= mul_p;
        if (mul_done && i_cmd.mul_to_x) r_x <= mul_p;
        if (mul_done && i_cmd.mul_to_b) r_b <= mul_p;
        if (i_cmd.set_simple) r_res <= simple;
        else if (i_cmd.set_zero_div) r_res <= '0;
        else if (mul_done && i_cmd.mul_to_b) r_res <= mul_p;
        else if (i_cmd.pow_init) r_res <= W'(1);
        else if (mul_done && i_cmd.mul_to_r) r_res <= mul_p;
        r_zd <= i_cmd.set_zero_div ? 1'b1 : (i_cmd.load ? 1'b0 : r_zd);
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= i_cmd.emit;
    end

    assign o_status.op       = r_op;
    assign o_status.a_zero   = (r_a == '0);
    assign o_status.b_zero   = (r_b == '0);
    assign o_status.e_zero   = (r_e == '0);
    assign o_status.e_lsb    = r_e[0];
    assign o_status.mul_done = mul_done;
    assign o_result_strobe   = r_strobe;
    assign o_result_value    = r_res;
    assign o_zero_divide     = r_zd;
endmodule

/* hdl/mau_ctrl.sv */
// Controller state machine sequencing reductions, exponentiation and multiplies.
`timescale 1ns / 1ps
module mau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mau_pkg::t_status i_status,
    output mau_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    mau_pkg::t_state r_state, n_state;
    logic r_started, n_started;
    logic r_phase, n_phase;   // power: 0 multiply into r, 1 square x

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mau_pkg::S_IDLE;
            r_started <= 1'b0;
            r_phase   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_phase   <= n_phase;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_phase   = r_phase;
        o_cmd     = '0;
        o_cmd.mul_src = mau_pkg::MS_A_B;
        o_busy    = (r_state != mau_pkg::S_IDLE);
        unique case (r_state)
            mau_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_started  = 1'b0;
                    n_state    = mau_pkg::S_RED_A;
                end
            end
            mau_pkg::S_RED_A: begin
                o_cmd.red_a = 1'b1;
                o_cmd.mul_start = !r_started;
                n_started = 1'b1;
                if (i_status.mul_done) begin
                    n_started = 1'b0;
                    n_state   = mau_pkg::S_RED_B;
                end
            end
            mau_pkg::S_RED_B: begin
                o_cmd.red_b = 1'b1;
                o_cmd.mul_start = !r_started;
                n_started = 1'b1;
                if (i_status.mul_done) begin
                    n_started = 1'b0;
                    n_state   = mau_pkg::S_DISPATCH;
                end
            end
            mau_pkg::S_DISPATCH: begin
                n_phase = 1'b0;
                priority if (i_status.op == mau_pkg::OP_ADD || i_status.op == mau_pkg::OP_SUB) begin
                    o_cmd.set_simple = 1'b1;
                    n_state = mau_pkg::S_DONE;
                end else if (i_status.op == mau_pkg::OP_MUL) begin
                    n_state = mau_pkg::S_MUL_RUN;
                end else if ((i_status.op == mau_pkg::OP_DIV && i_status.b_zero) ||
                             (i_status.op == mau_pkg::OP_INV && i_status.a_zero)) begin
                    o_cmd.set_zero_div = 1'b1;
                    n_state = mau_pkg::S_DONE;
                end else if (i_status.op == mau_pkg::OP_DIV || i_status.op == mau_pkg::OP_INV ||
                             i_status.op == mau_pkg::OP_POW) begin
                    o_cmd.pow_init = 1'b1;
                    n_state = mau_pkg::S_POW_STEP;
                end else begin
                    // Unknown operation: the simple path yields zero.
                    o_cmd.set_simple = 1'b1;
                    n_state = mau_pkg::S_DONE;
                end
            end
            mau_pkg::S_POW_STEP: begin
                // One exponent bit: optional r*=x, then x*=x, then shift.
                if (i_status.e_zero) begin
                    if (i_status.op == mau_pkg::OP_DIV) begin
                        n_state = mau_pkg::S_MUL_RUN;
                    end else begin
                        n_state = mau_pkg::S_DONE;
                    end
                end else if (!r_phase && !i_status.e_lsb) begin
                    n_phase = 1'b1;
                end else begin
                    o_cmd.mul_start = !r_started;
                    o_cmd.mul_src   = r_phase ? mau_pkg::MS_X_X : mau_pkg::MS_R_X;
                    o_cmd.mul_to_r  = !r_phase;
                    o_cmd.mul_to_x  = r_phase;
                    n_started = 1'b1;
                    if (i_status.mul_done) begin
                        n_started = 1'b0;
                        if (r_phase) begin
                            o_cmd.pow_shift = 1'b1;
                            n_phase = 1'b0;
                        end else begin
                            n_phase = 1'b1;
                        end
                    end
                end
            end
            mau_pkg::S_MUL_RUN: begin
                // Product a*b, or a*inverse(b) with inverse already in r.
                o_cmd.mul_start = !r_started;
                o_cmd.mul_src   = (i_status.op == mau_pkg::OP_DIV) ? mau_pkg::MS_A_R
                                                                  : mau_pkg::MS_A_B;
                o_cmd.mul_to_b  = 1'b1;
                n_started = 1'b1;
                if (i_status.mul_done) begin
                    n_started = 1'b0;
                    n_state   = mau_pkg::S_DONE;
                end
            end
            mau_pkg::S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = mau_pkg::S_IDLE;
            end
            default: n_state = mau_pkg::S_IDLE;
        endcase
    end

    property p_emit_from_done;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.emit |=> r_state == mau_pkg::S_IDLE;
    endproperty
    a_emit_idle: assert property (p_emit_from_done) else $error("emit not followed by idle");

    property p_load_only_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.load |-> !o_busy;
    endproperty
    a_load_idle: assert property (p_load_only_idle) else $error("load while busy");

    property p_start_once;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.mul_start |=> !o_cmd.mul_start;
    endproperty
    a_start_once: assert property (p_start_once) else $error("multiplier restarted");
endmodule

/* hdl/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit: controller and datapath.
`timescale 1ns / 1ps
// Modular arithmetic unit. A word is taken when start is high and busy is low;
// its result appears on o_result_value and o_zero_divide for one cycle with
// o_result_strobe high, and the receiver cannot stall it. Both operands are first
// reduced through the bit-serial multiplier. Add and subtract then finish without
// the multiplier; multiply runs one more product. Power, inverse and divide run
// square-and-multiply over the exponent (modulus-2 for inverse and divide): each
// exponent bit takes a multiply into r when the bit is set, then a squaring of x;
// divide adds one last multiply. All products use the shared W-step multiplier.
// i_modulus_we writes the modulus.
module modular_arithmetic_unit #(
    parameter int RESIDUE_WIDTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_modulus_we,
    input  logic [RESIDUE_WIDTH-1:0] i_modulus,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_req_type,
    input  logic [RESIDUE_WIDTH-1:0] i_operand_a,
    input  logic [RESIDUE_WIDTH-1:0] i_operand_b,
    input  logic [30:0]              i_exponent,
    output logic                     o_result_strobe,
    output logic [RESIDUE_WIDTH-1:0] o_result_value,
    output logic                     o_zero_divide
);
    mau_pkg::t_cmd    cmd;
    mau_pkg::t_status status;

    mau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    mau_datapath #(.W(RESIDUE_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_modulus_we),
        .i_cfg_data      (i_modulus),
        .i_req_type      (i_req_type),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .i_exponent      (i_exponent),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_result_strobe (o_result_strobe),
        .o_result_value  (o_result_value),
        .o_zero_divide   (o_zero_divide)
    );
endmodule
